>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the matrix multiply unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/dmm_pkg.sv
// Shared types, constants and helpers of the dense matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

   // Default parameter values
   localparam int DEF_MAX_DIM      = 8;
   localparam int DEF_ELEMENT_BITS = 16;

   // Fixed field widths
   localparam int DIM_BITS       = 4;
   localparam int IDX_BITS       = 3;
   localparam int ELEM_IN_BITS   = 16;
   localparam int VALUE_BITS     = 36;
   localparam int OP_BITS        = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   // Size register reset value, before clamping
   localparam logic [DIM_BITS-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_INNER_K = 2'd1,
      CSR_COLS_N  = 2'd2
   } csr_index_type;

   // Control token handed from cell to cell along with the A element
   typedef struct packed {
      logic                valid;
      logic                first;
      logic [DIM_BITS-1:0] k;
   } cell_ctrl_type;

   // Zero reads as one, anything above the array size as the array size
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input int unsigned max_dim);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_BITS'(max_dim);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dmm_req_if.sv
// Request channel: load and compute beats into the matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none

interface dmm_req_if;
   import dmm_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [OP_BITS-1:0]             operation;
   logic [IDX_BITS-1:0]            elem_row;
   logic [IDX_BITS-1:0]            elem_col;
   logic signed [ELEM_IN_BITS-1:0] elem_value;

   modport source (output valid, operation, elem_row, elem_col, elem_value, input ready);
   modport sink   (input valid, operation, elem_row, elem_col, elem_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dmm_rsp_if.sv
// Response channel: result element beats out of the matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none

interface dmm_rsp_if;
   import dmm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [IDX_BITS-1:0]          out_row;
   logic [IDX_BITS-1:0]          out_col;
   logic signed [VALUE_BITS-1:0] out_value;
   logic                         last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dense_matrix_multiply_unit.sv
// Top level of the dense matrix multiply unit: sequencer, A store and the cell chain.
//
// Usage:
//   req carries beats of operation, elem_row, elem_col, elem_value. A load-A or
//   load-B beat writes one element, and the next beat can follow
//   at once. Loads outside the configured shape and operation 3 are dropped.
//   A compute beat streams every result C[i][j] on rsp in row-major order, with
//   last set on the final element; req stays not ready until that beat is taken.
//   Per row the unit reads inner_k elements of A, one element a cycle, into a
//   chain of MAX_DIM column cells, waits in the drain state while the products
//   travel down the chain and settle, then shifts cols_n result beats out of
//   cell zero. A stall on rsp holds the current result and the whole sequence.
//   csr writes set rows_m, inner_k and cols_n (0 reads as 1, values above MAX_DIM
//   as MAX_DIM). The user makes them only while the unit is idle; it is not checked.
//   Reset is synchronous: the sizes return to 8 (clamped to MAX_DIM) and the unit
//   goes idle. The A and B stores are not cleared; compute only what was loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dense_matrix_multiply_unit #(
   parameter int MAX_DIM      = dmm_pkg::DEF_MAX_DIM,
   parameter int ELEMENT_BITS = dmm_pkg::DEF_ELEMENT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dmm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dmm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   dmm_req_if.sink                              req,
   dmm_rsp_if.source                            rsp
);
   import dmm_pkg::*;

   localparam int A_AW   = $clog2(MAX_DIM * MAX_DIM);
   localparam int WAIT_W = DIM_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [DIM_BITS-1:0]   rows_ff, inner_ff, cols_ff;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [DIM_BITS-1:0]   k_ff, k_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in;
   cell_ctrl_type         feed_ctrl_ff, feed_ctrl_in;

   logic                           req_beat;
   logic                           rsp_beat;
   logic                           last_beat;
   logic                           load_a_we;
   logic                           load_b_hit;
   logic [A_AW-1:0]                a_wr_addr;
   logic [A_AW-1:0]                a_rd_addr;
   logic                           a_rd_en;
   logic signed [ELEMENT_BITS-1:0] elem_data;
   logic signed [ELEMENT_BITS-1:0] a_rd_data;

   cell_ctrl_type                  ctrl_link [MAX_DIM];
   logic signed [ELEMENT_BITS-1:0] a_link    [MAX_DIM];
   logic signed [VALUE_BITS-1:0]   acc_link  [MAX_DIM];
   logic [MAX_DIM-1:0]             b_wr_en;

   assign req_beat = req.valid && req.ready;
   assign rsp_beat = rsp.valid && rsp.ready;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= clamp_dim(SIZE_RESET, MAX_DIM);
         inner_ff <= clamp_dim(SIZE_RESET, MAX_DIM);
         cols_ff  <= clamp_dim(SIZE_RESET, MAX_DIM);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_M:  rows_ff  <= clamp_dim(csr_data, MAX_DIM);
            CSR_INNER_K: inner_ff <= clamp_dim(csr_data, MAX_DIM);
            CSR_COLS_N:  cols_ff  <= clamp_dim(csr_data, MAX_DIM);
            default: ;
         endcase
      end
   end

   // element width adaptation
   generate
      if (ELEMENT_BITS > ELEM_IN_BITS) begin : g_elem_wide
         assign elem_data = {{(ELEMENT_BITS - ELEM_IN_BITS){1'b0}}, req.elem_value};
      end else begin : g_elem_narrow
         assign elem_data = req.elem_value[ELEMENT_BITS-1:0];
      end
   endgenerate

   // load decode, shape checks drop out-of-range elements
   assign load_a_we  = req_beat && (req.operation == OP_LOAD_A)
                       && (DIM_BITS'(req.elem_row) < rows_ff)
                       && (DIM_BITS'(req.elem_col) < inner_ff);
   assign load_b_hit = req_beat && (req.operation == OP_LOAD_B)
                       && (DIM_BITS'(req.elem_row) < inner_ff)
                       && (DIM_BITS'(req.elem_col) < cols_ff);
   assign a_wr_addr  = A_AW'(int'(req.elem_row) * MAX_DIM + int'(req.elem_col));
   assign a_rd_addr  = A_AW'(int'(row_ff) * MAX_DIM + int'(k_ff));
   assign a_rd_en    = (state_ff == ST_FEED);

   dmm_ram #(
      .WIDTH(ELEMENT_BITS),
      .DEPTH(MAX_DIM * MAX_DIM)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (load_a_we),
      .wr_addr (a_wr_addr),
      .wr_data (elem_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      col_in       = col_ff;
      wait_in      = wait_ff;
      feed_ctrl_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req.operation == OP_COMPUTE)) begin
               row_in   = '0;
               k_in     = '0;
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            feed_ctrl_in.valid = 1'b1;
            feed_ctrl_in.first = (k_ff == '0);
            feed_ctrl_in.k     = k_ff;
            if (k_ff == inner_ff - DIM_BITS'(1)) begin
               k_in     = '0;
               wait_in  = WAIT_W'(cols_ff) + WAIT_W'(1);
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (wait_ff == '0) begin
               col_in   = '0;
               state_in = ST_EMIT;
            end else begin
               wait_in = wait_ff - WAIT_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_beat) begin
               if (col_ff == cols_ff - DIM_BITS'(1)) begin
                  col_in = '0;
                  if (row_ff == rows_ff - DIM_BITS'(1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in   = row_ff + DIM_BITS'(1);
                     state_in = ST_FEED;
                  end
               end else begin
                  col_in = col_ff + DIM_BITS'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         k_ff         <= '0;
         col_ff       <= '0;
         wait_ff      <= '0;
         feed_ctrl_ff <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         col_ff       <= col_in;
         wait_ff      <= wait_in;
         feed_ctrl_ff <= feed_ctrl_in;
      end
   end

   // chain of column cells
   assign ctrl_link[0] = feed_ctrl_ff;
   assign a_link[0]    = a_rd_data;

   generate
      for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
         logic signed [VALUE_BITS-1:0] acc_right;

         assign b_wr_en[j] = load_b_hit && (int'(req.elem_col) == j);

         if (j == MAX_DIM - 1) begin : g_end
            assign acc_right = '0;
            dmm_cell #(
               .MAX_DIM      (MAX_DIM),
               .ELEMENT_BITS (ELEMENT_BITS)
            ) u_cell (
               .clock        (clock),
               .reset        (reset),
               .ctrl_in      (ctrl_link[j]),
               .a_in         (a_link[j]),
               .ctrl_out     (),
               .a_out        (),
               .b_wr_en      (b_wr_en[j]),
               .b_wr_addr    (req.elem_row),
               .b_wr_data    (elem_data),
               .shift        (rsp_beat),
               .acc_right_in (acc_right),
               .acc_out      (acc_link[j])
            );
         end else begin : g_mid
            assign acc_right = acc_link[j+1];
            dmm_cell #(
               .MAX_DIM      (MAX_DIM),
               .ELEMENT_BITS (ELEMENT_BITS)
            ) u_cell (
               .clock        (clock),
               .reset        (reset),
               .ctrl_in      (ctrl_link[j]),
               .a_in         (a_link[j]),
               .ctrl_out     (ctrl_link[j+1]),
               .a_out        (a_link[j+1]),
               .b_wr_en      (b_wr_en[j]),
               .b_wr_addr    (req.elem_row),
               .b_wr_data    (elem_data),
               .shift        (rsp_beat),
               .acc_right_in (acc_right),
               .acc_out      (acc_link[j])
            );
         end
      end
   endgenerate

   // result beat comes from cell zero
   assign last_beat     = (row_ff == rows_ff - DIM_BITS'(1))
                          && (col_ff == cols_ff - DIM_BITS'(1));
   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = (state_ff == ST_EMIT);
   assign rsp.out_row   = row_ff[IDX_BITS-1:0];
   assign rsp.out_col   = col_ff[IDX_BITS-1:0];
   assign rsp.out_value = acc_link[0];
   assign rsp.last      = last_beat;

   // checks
   `ASSERT_NEVER(a_busy_accept, clock, reset, rsp.valid && req.ready,
                 "request taken while results are pending")
   `ASSERT_CLK(a_last_idle, clock, reset, rsp_beat && rsp.last |=> req.ready,
               "unit not idle after last result beat")
   `ASSERT_CLK(a_compute_busy, clock, reset,
               req_beat && (req.operation == OP_COMPUTE) |=> !req.ready,
               "compute beat did not start the sequence")
   `ASSERT_NEVER(a_col_range, clock, reset, (state_ff == ST_EMIT) && (col_ff >= cols_ff),
                 "result column beyond configured width")
endmodule

`default_nettype wire

>>> hw/rtl/dmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

>>> hw/rtl/dmm_cell.sv
// One column cell: holds a column of B, multiplies the passing A element, accumulates.
`timescale 1ns / 1ps
`default_nettype none

module dmm_cell #(
   parameter int MAX_DIM      = dmm_pkg::DEF_MAX_DIM,
   parameter int ELEMENT_BITS = dmm_pkg::DEF_ELEMENT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // token chain from the left neighbor and to the right neighbor
   input  dmm_pkg::cell_ctrl_type                ctrl_in,
   input  logic signed [ELEMENT_BITS-1:0]        a_in,
   output dmm_pkg::cell_ctrl_type                ctrl_out,
   output logic signed [ELEMENT_BITS-1:0]        a_out,
   // B column load
   input  logic                                  b_wr_en,
   input  logic [dmm_pkg::IDX_BITS-1:0]          b_wr_addr,
   input  logic signed [ELEMENT_BITS-1:0]        b_wr_data,
   // result shift chain, moves toward cell zero
   input  logic                                  shift,
   input  logic signed [dmm_pkg::VALUE_BITS-1:0] acc_right_in,
   output logic signed [dmm_pkg::VALUE_BITS-1:0] acc_out
);
   import dmm_pkg::*;

   localparam int KW = $clog2(MAX_DIM);

   cell_ctrl_type                  ctrl_ff;
   logic signed [ELEMENT_BITS-1:0] a_ff;
   logic signed [ELEMENT_BITS-1:0] b_rd_data;
   logic signed [2*ELEMENT_BITS-1:0] mul_full;
   logic                           prod_valid_ff;
   logic                           prod_first_ff;
   logic signed [VALUE_BITS-1:0]   prod_ff;
   logic signed [VALUE_BITS-1:0]   acc_ff;
   logic signed [VALUE_BITS-1:0]   acc_in;

   // column k of B is read as the token arrives, data lines up with ctrl_ff
   dmm_ram #(
      .WIDTH(ELEMENT_BITS),
      .DEPTH(MAX_DIM)
   ) u_b_col (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (KW'(b_wr_addr)),
      .wr_data (b_wr_data),
      .rd_en   (ctrl_in.valid),
      .rd_addr (KW'(ctrl_in.k)),
      .rd_data (b_rd_data)
   );

   assign mul_full = a_ff * b_rd_data;

   // accumulate, or shift results toward the output end
   always_comb begin
      priority if (shift) begin
         acc_in = acc_right_in;
      end else if (prod_valid_ff) begin
         acc_in = prod_first_ff ? prod_ff : acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= '0;
         prod_valid_ff <= 1'b0;
         prod_first_ff <= 1'b0;
      end else begin
         ctrl_ff       <= ctrl_in;
         prod_valid_ff <= ctrl_ff.valid;
         prod_first_ff <= ctrl_ff.first;
      end
   end

   // data pipeline
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= VALUE_BITS'(mul_full);
      acc_ff  <= acc_in;
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign acc_out  = acc_ff;
endmodule

`default_nettype wire

>>> bench/tb_dense_matrix_multiply_unit.sv
// Self-checking bench for the dense matrix multiply unit: directed and random loads and products.
`timescale 1ns / 1ps

module tb_dense_matrix_multiply_unit;
   import dmm_pkg::*;

   localparam int DIM           = DEF_MAX_DIM;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 1000000;

   // Codes the package leaves unnamed
   localparam logic [OP_BITS-1:0]        OP_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [OP_BITS-1:0]             op;
      logic [IDX_BITS-1:0]            row;
      logic [IDX_BITS-1:0]            col;
      logic signed [ELEM_IN_BITS-1:0] value;
      bit                             wait_drain;  // hold back until all results are in
      bit                             hold_rsp;    // starts a long receiver hold-off
   } req_item;

   typedef struct {
      logic [IDX_BITS-1:0]   row;
      logic [IDX_BITS-1:0]   col;
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } dot_result;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   dmm_req_if req_if ();
   dmm_rsp_if rsp_if ();

   dense_matrix_multiply_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_if),
      .rsp       (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Matrix shadow, sizes and result store
   logic signed [ELEM_IN_BITS-1:0] shadow_a [DIM*DIM];
   logic signed [ELEM_IN_BITS-1:0] shadow_b [DIM*DIM];
   int        cur_rows = DIM;
   int        cur_inner = DIM;
   int        cur_cols = DIM;
   dot_result expected_dots [$];

   // Which entries the queued stimulus has written (never cleared)
   bit a_loaded [DIM*DIM];
   bit b_loaded [DIM*DIM];

   req_item     pending_reqs [$];
   req_item     cur_item;
   bit          sender_busy = 1'b0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int          hold_left = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   function automatic int fit_dim(input logic [CSR_DATA_BITS-1:0] raw);
      if (raw == '0) return 1;
      if (int'(raw) > DIM) return DIM;
      return int'(raw);
   endfunction

   function automatic logic [ELEM_IN_BITS-1:0] pick_value();
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return ELEM_IN_BITS'($urandom_range(65535));
   endfunction

   // Apply one accepted beat to the shadow; a product queues every C[i][j]
   task automatic update_product_model(input req_item it);
      longint    acc;
      dot_result d;
      case (it.op)
         OP_LOAD_A: begin
            if (it.row < cur_rows && it.col < cur_inner) shadow_a[it.row*DIM+it.col] = it.value;
         end
         OP_LOAD_B: begin
            if (it.row < cur_inner && it.col < cur_cols) shadow_b[it.row*DIM+it.col] = it.value;
         end
         OP_COMPUTE: begin
            for (int i = 0; i < cur_rows; i++) begin
               for (int j = 0; j < cur_cols; j++) begin
                  acc = 0;
                  for (int kk = 0; kk < cur_inner; kk++) begin
                     acc += longint'(shadow_a[i*DIM+kk]) * longint'(shadow_b[kk*DIM+j]);
                  end
                  d.row   = IDX_BITS'(i);
                  d.col   = IDX_BITS'(j);
                  d.value = acc[VALUE_BITS-1:0];
                  d.last  = (i == cur_rows - 1) && (j == cur_cols - 1);
                  expected_dots.push_back(d);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Queue one request and note which entries it fills
   task automatic add_item(input logic [OP_BITS-1:0] op, input int row, input int col,
                           input logic [ELEM_IN_BITS-1:0] value, input bit wait_drain,
                           input bit hold_rsp);
      req_item it;
      it.op         = op;
      it.row        = IDX_BITS'(row);
      it.col        = IDX_BITS'(col);
      it.value      = value;
      it.wait_drain = wait_drain;
      it.hold_rsp   = hold_rsp;
      if (op == OP_LOAD_A && row < cur_rows && col < cur_inner) a_loaded[row*DIM+col] = 1'b1;
      if (op == OP_LOAD_B && row < cur_inner && col < cur_cols) b_loaded[row*DIM+col] = 1'b1;
      pending_reqs.push_back(it);
   endtask

   // Load every entry the current shape reads that was never written, in random order
   task automatic fill_missing();
      int slots [$];
      int pick;
      int s;
      for (int r = 0; r < cur_rows; r++) begin
         for (int c = 0; c < cur_inner; c++) begin
            if (!a_loaded[r*DIM+c]) slots.push_back(r*DIM+c);
         end
      end
      for (int r = 0; r < cur_inner; r++) begin
         for (int c = 0; c < cur_cols; c++) begin
            if (!b_loaded[r*DIM+c]) slots.push_back(DIM*DIM + r*DIM+c);
         end
      end
      while (slots.size() > 0) begin
         pick = $urandom_range(slots.size() - 1);
         s = slots[pick];
         slots.delete(pick);
         if (s < DIM*DIM) add_item(OP_LOAD_A, s / DIM, s % DIM, pick_value(), 1'b0, 1'b0);
         else add_item(OP_LOAD_B, (s - DIM*DIM) / DIM, (s - DIM*DIM) % DIM, pick_value(),
                       1'b0, 1'b0);
      end
   endtask

   // Mostly in-shape loads and products, some stray loads and unused ops
   task automatic add_random(input int count, input bit pause_once);
      int                 roll;
      int                 row;
      int                 col;
      logic [OP_BITS-1:0] op;
      if (pause_once) add_item(OP_COMPUTE, $urandom_range(7), $urandom_range(7), pick_value(),
                               1'b0, 1'b0);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         row  = $urandom_range(7);
         col  = $urandom_range(7);
         if (roll < 22) begin
            op = OP_COMPUTE;
         end else if (roll < 72) begin
            op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
            if (op == OP_LOAD_A) begin
               row = $urandom_range(cur_rows - 1);
               col = $urandom_range(cur_inner - 1);
            end else begin
               row = $urandom_range(cur_inner - 1);
               col = $urandom_range(cur_cols - 1);
            end
         end else if (roll < 90) begin
            op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
         end else begin
            op = OP_UNUSED;
         end
         add_item(op, row, col, pick_value(), pause_once && n == 0, 1'b0);
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || sender_busy || expected_dots.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_ROWS_M:  cur_rows = fit_dim(data);
         CSR_INNER_K: cur_inner = fit_dim(data);
         CSR_COLS_N:  cur_cols = fit_dim(data);
         default: ;
      endcase
   endtask

   // Wait for the unit to go quiet, then set sizes and idling for the next phase
   task automatic set_phase(input logic [CSR_DATA_BITS-1:0] m, input logic [CSR_DATA_BITS-1:0] k,
                            input logic [CSR_DATA_BITS-1:0] n, input int s_idle,
                            input int r_idle, input bit spare);
      wait_idle();
      write_csr(CSR_ROWS_M, m);
      write_csr(CSR_INNER_K, k);
      write_csr(CSR_COLS_N, n);
      if (spare) write_csr(CSR_SPARE, CSR_DATA_BITS'($urandom_range(15)));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      send_idle = s_idle;
      recv_idle = r_idle;
   endtask

   // Request driver: a beat stays offered until taken
   always @(posedge clock) begin : req_driver
      bit busy;
      if (reset) begin
         busy = 1'b0;
      end else begin
         busy = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            update_product_model(cur_item);
            if (cur_item.hold_rsp) hold_requests++;
            busy = 1'b0;
         end
         if (!busy && pending_reqs.size() > 0 &&
             !(pending_reqs[0].wait_drain && expected_dots.size() != 0) &&
             $urandom_range(99) >= send_idle) begin
            cur_item = pending_reqs.pop_front();
            busy = 1'b1;
         end
      end
      sender_busy = busy;
      req_if.valid      <= busy;
      req_if.operation  <= cur_item.op;
      req_if.elem_row   <= cur_item.row;
      req_if.elem_col   <= cur_item.col;
      req_if.elem_value <= cur_item.value;
   end

   // Result monitor: checks each beat against the oldest expected dot product
   always @(posedge clock) begin : rsp_monitor
      dot_result want;
      bit        go;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_dots.size() == 0) begin
               $display("%0t: unexpected result beat row %0d col %0d value %h", $time,
                        rsp_if.out_row, rsp_if.out_col, rsp_if.out_value);
               failures++;
            end else begin
               want = expected_dots.pop_front();
               if (rsp_if.out_row !== want.row) begin
                  $display("%0t: out_row expected %0d actual %0d", $time, want.row,
                           rsp_if.out_row);
                  failures++;
               end
               if (rsp_if.out_col !== want.col) begin
                  $display("%0t: out_col expected %0d actual %0d", $time, want.col,
                           rsp_if.out_col);
                  failures++;
               end
               if (rsp_if.out_value !== want.value) begin
                  $display("%0t: out_value C[%0d][%0d] expected %h actual %h", $time,
                           want.row, want.col, want.value, rsp_if.out_value);
                  failures++;
               end
               if (rsp_if.last !== want.last) begin
                  $display("%0t: last C[%0d][%0d] expected %b actual %b", $time, want.row,
                           want.col, want.last, rsp_if.last);
                  failures++;
               end
            end
         end
         // long hold-off, then random stalls
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            go = 1'b0;
         end else begin
            go = ($urandom_range(99) >= recv_idle);
         end
         rsp_if.ready <= go;
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d results still expected", $time, expected_dots.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      req_if.valid      = 1'b0;
      req_if.operation  = '0;
      req_if.elem_row   = '0;
      req_if.elem_col   = '0;
      req_if.elem_value = '0;
      rsp_if.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme products, dropped loads at the shape edge, unused op
      set_phase(4'd2, 4'd2, 4'd2, 35, 55, 1'b0);
      add_item(OP_LOAD_A, 0, 0, 16'h7FFF, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 0, 1, 16'h8000, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 1, 0, 16'h8000, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 1, 1, 16'h0100, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 0, 0, 16'h8000, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 0, 1, 16'h7FFF, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 1, 0, 16'h8000, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 1, 1, 16'hFFFF, 1'b0, 1'b0);
      add_item(OP_COMPUTE, 7, 7, 16'hFFFF, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 2, 0, 16'h1234, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 0, 2, 16'h1234, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 7, 7, 16'h5555, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 2, 1, 16'h1234, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 1, 2, 16'h1234, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 7, 0, 16'h5555, 1'b0, 1'b0);
      add_item(OP_UNUSED, 7, 7, 16'hFFFF, 1'b0, 1'b0);
      add_item(OP_COMPUTE, 0, 0, 16'h0000, 1'b0, 1'b0);
      add_item(OP_LOAD_A, 1, 1, 16'h0000, 1'b0, 1'b0);
      add_item(OP_LOAD_B, 0, 0, 16'h7FFF, 1'b0, 1'b0);
      add_item(OP_COMPUTE, 3, 5, 16'hA5A5, 1'b0, 1'b0);

      // Receiver idles more than sender
      set_phase(4'd1, 4'd1, 4'd1, 35, 55, 1'b0);
      fill_missing();
      add_random(10, 1'b0);

      // Receiver holds off on the first product so requests back up
      set_phase(4'd3, 4'd4, 4'd2, 35, 55, 1'b0);
      fill_missing();
      add_item(OP_COMPUTE, 0, 0, 16'h0000, 1'b0, 1'b1);
      add_random(12, 1'b0);

      // Sender idles more than receiver
      set_phase(4'd8, 4'd8, 4'd8, 55, 35, 1'b0);
      fill_missing();
      add_random(10, 1'b0);

      // Out-of-range sizes clamp; sender waits once for all results
      set_phase(4'd0, 4'd15, 4'd5, 55, 35, 1'b0);
      fill_missing();
      add_random(12, 1'b1);

      set_phase(4'd8, 4'd1, 4'd8, 55, 35, 1'b1);
      fill_missing();
      add_random(10, 1'b0);

      // No idling on either side
      set_phase(4'd1, 4'd8, 4'd1, 0, 0, 1'b0);
      fill_missing();
      add_random(10, 1'b0);

      repeat (3) begin
         set_phase(CSR_DATA_BITS'($urandom_range(4, 1)), CSR_DATA_BITS'($urandom_range(4, 1)),
                   CSR_DATA_BITS'($urandom_range(4, 1)), 0, 0, 1'b0);
         fill_missing();
         add_random(10, 1'b0);
      end

      wait_idle();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/dmm_pkg.sv
hw/rtl/dmm_req_if.sv
hw/rtl/dmm_rsp_if.sv
hw/rtl/dmm_ram.sv
hw/rtl/dmm_cell.sv
hw/rtl/dense_matrix_multiply_unit.sv
bench/tb_dense_matrix_multiply_unit.sv
